### rtl/core/giru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Genotype index package
// Shared constants, types and the binomial coefficient tables.
// ----------------------------------------------------------------------------
package giru_pkg;

   localparam int unsigned MaxPos = 15;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_PLOIDY = 2'd1,
      ERR_ALLELE = 2'd2
   } err_type;

   // Binomial coefficient C(n,k) for small n; the largest value used, C(30,15),
   // fits in 34 bits. Only evaluated on constants while building tables.
   function automatic logic [33:0] binom(input logic [5:0] n, input logic [4:0] k);
      logic [63:0] r;
      int i;
      r = 64'd1;
      if ({1'b0, k} > n) begin
         r = 64'd0;
      end else begin
         for (i = 0; i < 15; i++) begin
            if (i < int'(k)) begin
               r = r * 64'(int'(n) - i) / 64'(i + 1);
            end
         end
      end
      return r[33:0];
   endfunction

   // Sixteen coefficients C(n0+a, k) for a = 0..15, 34 bits each.
   function automatic logic [16*34-1:0] binom_row(input int unsigned n0,
                                                  input int unsigned k);
      logic [16*34-1:0] row;
      row = '0;
      for (int a = 0; a < 16; a++) begin
         row[a*34 +: 34] = binom(6'(n0) + 6'(a), 5'(k));
      end
      return row;
   endfunction

   // Number of genotypes C(p+allele_count-1, p) for p = 0..15, 34 bits each.
   function automatic logic [16*34-1:0] count_row(input int unsigned allele_count);
      logic [16*34-1:0] row;
      row = '0;
      for (int p = 0; p < 16; p++) begin
         row[p*34 +: 34] = binom(6'(p) + 6'(allele_count) - 6'd1, 5'(p));
      end
      return row;
   endfunction

   // Nibble sorting state carried along the chain.
   typedef struct packed {
      logic        valid;
      logic        cmd;
      logic [3:0]  ploidy;
      logic [1:0]  err;
      logic [59:0] alleles;  // ascending for rank, nibble k-1 = k-th smallest
      logic [34:0] acc;      // rank sum or unrank remainder
      logic [31:0] index_in;
   } stage_type;

endpackage

### rtl/core/giru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Genotype index chain cell
// One position of the chain. For rank it inserts one allele into the sorted
// list; for unrank it recovers the allele at its position from the remainder.
// ----------------------------------------------------------------------------
module giru_cell #(
   parameter int unsigned POS          = 0,
   parameter int unsigned ALLELE_COUNT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  giru_pkg::stage_type  stage_in,
   output giru_pkg::stage_type  stage_out
);

   // Unrank position handled here: the first cell takes the highest position.
   localparam int unsigned K = giru_pkg::MaxPos - POS;
   localparam logic [16*34-1:0] Coef = giru_pkg::binom_row(K - 1, K);

   giru_pkg::stage_type next_in, stage_ff;
   logic [3:0]  a_new;
   logic [59:0] ins;
   logic [3:0]  best;
   logic [33:0] coef;
   logic        lt;

   always_comb begin
      next_in = stage_in;
      a_new   = stage_in.alleles[POS*4 +: 4];
      ins     = stage_in.alleles;
      best    = '0;
      coef    = '0;
      lt      = 1'b0;
      if (stage_in.cmd == 1'b0) begin
         // Rank: raw allele POS sits at nibble POS; the lower POS nibbles are
         // sorted. Insertion keeps the lower nibbles ascending.
         if (POS < int'(stage_in.ploidy)) begin
            if (32'(a_new) >= ALLELE_COUNT && stage_in.err == giru_pkg::ERR_NONE) begin
               next_in.err = giru_pkg::ERR_ALLELE;
            end
            for (int j = 0; j < 15; j++) begin
               if (j <= POS) begin
                  if (j == 0) begin
                     lt = 1'b0;
                  end else begin
                     lt = stage_in.alleles[(j-1)*4 +: 4] > a_new;
                  end
                  if (j < POS && stage_in.alleles[j*4 +: 4] > a_new) begin
                     if (j == 0 || !lt) ins[j*4 +: 4] = a_new;
                     else ins[j*4 +: 4] = stage_in.alleles[(j-1)*4 +: 4];
                  end else if (j == POS) begin
                     if (POS > 0 && lt) ins[j*4 +: 4] = stage_in.alleles[(j-1)*4 +: 4];
                     else ins[j*4 +: 4] = a_new;
                  end
               end
            end
            next_in.alleles = ins;
         end
      end else begin
         if (K <= 32'(stage_in.ploidy)) begin
            for (int a = 1; a < 16; a++) begin
               if (a < ALLELE_COUNT &&
                   {1'b0, Coef[a*34 +: 34]} <= stage_in.acc) begin
                  best = 4'(a);
               end
            end
            coef = Coef[best*34 +: 34];
            next_in.acc = stage_in.acc - {1'b0, coef};
            next_in.alleles[(K-1)*4 +: 4] = best;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.cmd      <= next_in.cmd;
      stage_ff.ploidy   <= next_in.ploidy;
      stage_ff.err      <= next_in.err;
      stage_ff.alleles  <= next_in.alleles;
      stage_ff.acc      <= next_in.acc;
      stage_ff.index_in <= next_in.index_in;
   end

   assign stage_out = stage_ff;

endmodule

### rtl/core/giru_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Genotype index rank sum chain cell
// Adds one position's coefficient C(k+a-1,k) of the sorted alleles to the sum.
// ----------------------------------------------------------------------------
module giru_sum #(
   parameter int unsigned POS = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  giru_pkg::stage_type  stage_in,
   output giru_pkg::stage_type  stage_out
);

   localparam logic [16*34-1:0] Coef = giru_pkg::binom_row(POS, POS + 1);

   giru_pkg::stage_type next_in, stage_ff;
   logic [3:0] a;

   always_comb begin
      next_in = stage_in;
      a       = stage_in.alleles[POS*4 +: 4];
      if (stage_in.cmd == 1'b0 && POS < int'(stage_in.ploidy)) begin
         next_in.acc = stage_in.acc + {1'b0, Coef[a*34 +: 34]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.cmd      <= next_in.cmd;
      stage_ff.ploidy   <= next_in.ploidy;
      stage_ff.err      <= next_in.err;
      stage_ff.alleles  <= next_in.alleles;
      stage_ff.acc      <= next_in.acc;
      stage_ff.index_in <= next_in.index_in;
   end

   assign stage_out = stage_ff;

endmodule

### rtl/core/genotype_index_rank_unrank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Genotype index rank/unrank core
// Pipeline: one input stage, fifteen sort or recover cells, fifteen sum cells and
// one output stage lie between start and rsp_valid. Throughput: one
// transaction per cycle; busy stays low, the chain of cells sets the latency.
// Reset clears the valid bits of the chain; no result follows reset.
// ----------------------------------------------------------------------------
module genotype_index_rank_unrank_core #(
   parameter int unsigned PLOIDY_LIMIT = 15,
   parameter int unsigned ALLELE_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [3:0]  req_ploidy,
   input  logic [59:0] req_allele_word,
   input  logic [31:0] req_index_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_error_code,
   output logic [26:0] rsp_index_out,
   output logic [63:0] rsp_packed_code,
   output logic        rsp_empty_flag,
   output logic        rsp_homozygous_flag,
   output logic        rsp_diploid_biallelic_flag
);

   localparam int unsigned N = giru_pkg::MaxPos;
   localparam logic [16*34-1:0] GenotypeCount = giru_pkg::count_row(ALLELE_COUNT);

   giru_pkg::stage_type head_in, head_ff;
   giru_pkg::stage_type chain [0:2*N];
   giru_pkg::stage_type t;
   logic [33:0] total;
   logic [63:0] code;
   logic        homo, dib;
   logic [3:0]  av;

   assign busy = 1'b0;

   always_comb begin
      head_in.valid    = start;
      head_in.cmd      = req_cmd;
      head_in.ploidy   = req_ploidy;
      head_in.err      = giru_pkg::ERR_NONE;
      head_in.alleles  = req_cmd ? 60'd0 : req_allele_word;
      head_in.acc      = req_cmd ? {3'd0, req_index_in} : 35'd0;
      head_in.index_in = req_index_in;
      total = GenotypeCount[req_ploidy*34 +: 34];
      if (32'(req_ploidy) >= PLOIDY_LIMIT || req_ploidy == 4'd15) begin
         head_in.err = giru_pkg::ERR_PLOIDY;
      end else if (req_cmd && {2'd0, req_index_in} >= total) begin
         head_in.err = giru_pkg::ERR_ALLELE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else begin
         head_ff.valid <= head_in.valid;
      end
      head_ff.cmd      <= head_in.cmd;
      head_ff.ploidy   <= head_in.ploidy;
      head_ff.err      <= head_in.err;
      head_ff.alleles  <= head_in.alleles;
      head_ff.acc      <= head_in.acc;
      head_ff.index_in <= head_in.index_in;
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < N; g++) begin : g_cell
      giru_cell #(.POS(g), .ALLELE_COUNT(ALLELE_COUNT)) u_cell (
         .clock(clock), .reset(reset), .stage_in(chain[g]), .stage_out(chain[g+1])
      );
   end

   for (genvar g = 0; g < N; g++) begin : g_sum
      giru_sum #(.POS(g)) u_sum (
         .clock(clock), .reset(reset), .stage_in(chain[N+g]), .stage_out(chain[N+g+1])
      );
   end

   always_comb begin
      t    = chain[2*N];
      code = {t.ploidy, 60'd0};
      homo = t.ploidy != 4'd0;
      dib  = t.ploidy == 4'd2;
      av   = '0;
      for (int j = 0; j < 15; j++) begin
         if (j < int'(t.ploidy)) begin
            av = t.alleles[(int'(t.ploidy) - 1 - j)*4 +: 4];
            code[j*4 +: 4] = av;
            if (av != t.alleles[3:0]) homo = 1'b0;
            if (av > 4'd1) dib = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= t.valid;
      end
      if (t.err != giru_pkg::ERR_NONE) begin
         rsp_error_code             <= t.err;
         rsp_index_out              <= '0;
         rsp_packed_code            <= '0;
         rsp_empty_flag             <= 1'b0;
         rsp_homozygous_flag        <= 1'b0;
         rsp_diploid_biallelic_flag <= 1'b0;
      end else begin
         rsp_error_code             <= giru_pkg::ERR_NONE;
         rsp_index_out              <= t.cmd ? t.index_in[26:0] : t.acc[26:0];
         rsp_packed_code            <= code;
         rsp_empty_flag             <= t.ploidy == 4'd0;
         rsp_homozygous_flag        <= homo;
         rsp_diploid_biallelic_flag <= dib;
      end
   end

endmodule
